@@ rtl/core/pscf_pkg.sv @@
// ----------------------------------------------------------------------------
// Pitch swarm crossfader package
// Shared widths, constants, register indexes, state and control types.
// ----------------------------------------------------------------------------
package pscf_pkg;

    localparam int VOICES_DEF = 16;

    localparam int PITCH_W    = 17;
    localparam int IDX_W      = 4;
    localparam int COUNT_W    = 5;
    localparam int VOICE_W    = 4;
    localparam int WALK_W     = 26;
    localparam int STEP_W     = 16;
    localparam int SEED_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int WEIGHT_W   = 17;
    localparam int CHORDS     = 16;

    localparam logic [STEP_W-1:0] DRIFT_STEP_RESET = 16'd70;
    localparam logic [SEED_W-1:0] LFSR_RESET       = 32'd1;
    localparam logic [SEED_W-1:0] LFSR_TAPS        = 32'h8020_0003;

    localparam logic signed [18:0] ROOT_LOW_LIMIT  = -19'sd13926;
    localparam logic signed [18:0] ROOT_HIGH_LIMIT = 19'sd18022;
    localparam logic signed [18:0] ONE_V_MINUS_1   = 19'sd4095;

    localparam logic signed [PITCH_W-1:0] ENV_TOP    = 17'sd36864;
    localparam logic signed [PITCH_W-1:0] ENV_BOTTOM = 17'sd409;
    localparam logic [WEIGHT_W-1:0]       WEIGHT_ONE = 17'd65536;
    localparam logic [19:0]               RECIP_9    = 20'd932068;
    localparam logic [17:0]               CURVE_3    = 18'd196608;

    localparam logic signed [26:0] DRIFT_ROUND = 27'sd20480;
    localparam logic signed [14:0] DRIFT_BIAS  = 15'sd4200;
    localparam logic [15:0]        RECIP_10    = 16'd52429;
    localparam logic signed [17:0] SWARM_BIAS  = 18'sd2468;

    localparam logic signed [36:0] BLEND_ROUND = 37'sd32768;
    localparam logic signed [21:0] PITCH_MAX   = 22'sd40960;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DRIFT_STEP  = 2'd0,
        CFG_RANDOM_SEED = 2'd1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WEIGHT,
        ST_SQUARE,
        ST_CURVE,
        ST_WALK,
        ST_DRIFT,
        ST_SWARM,
        ST_BLEND,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic load_chord;
        logic calc_weight;
        logic calc_square;
        logic calc_curve;
        logic walk;
        logic drift;
        logic swarm;
        logic blend;
        logic emit;
        logic voice_next;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic last_voice;
    } stat_t;

endpackage

@@ rtl/core/pscf_in_if.sv @@
// ----------------------------------------------------------------------------
// Pitch swarm crossfader input channel
// Valid/ready channel carrying chord loads and sample ticks.
// ----------------------------------------------------------------------------
interface pscf_in_if import pscf_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [IDX_W-1:0]          chord_index;
    logic signed [PITCH_W-1:0] chord_value;
    logic signed [PITCH_W-1:0] root_pitch;
    logic signed [PITCH_W-1:0] envelope;
    logic [COUNT_W-1:0]        chord_count;

    modport source (
        output valid, kind, chord_index, chord_value, root_pitch, envelope, chord_count,
        input  ready
    );

    modport sink (
        input  valid, kind, chord_index, chord_value, root_pitch, envelope, chord_count,
        output ready
    );
endinterface

@@ rtl/core/pscf_out_if.sv @@
// ----------------------------------------------------------------------------
// Pitch swarm crossfader result channel
// Valid/ready channel carrying one blended pitch per voice.
// ----------------------------------------------------------------------------
interface pscf_out_if import pscf_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [VOICE_W-1:0]        voice;
    logic signed [PITCH_W-1:0] pitch;
    logic                      last;

    modport source (
        output valid, voice, pitch, last,
        input  ready
    );

    modport sink (
        input  valid, voice, pitch, last,
        output ready
    );
endinterface

@@ rtl/core/pscf_ctrl.sv @@
// ----------------------------------------------------------------------------
// Pitch swarm crossfader controller
// Sequences the per-tick setup steps and the five steps of each voice.
// ----------------------------------------------------------------------------
module pscf_ctrl import pscf_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  in_kind,
    output logic  in_ready,
    input  stat_t status,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_kind)
                begin
                    state_next = ST_WEIGHT;
                end
            end
            ST_WEIGHT: state_next = ST_SQUARE;
            ST_SQUARE: state_next = ST_CURVE;
            ST_CURVE:  state_next = ST_WALK;
            ST_WALK:   state_next = ST_DRIFT;
            ST_DRIFT:  state_next = ST_SWARM;
            ST_SWARM:  state_next = ST_BLEND;
            ST_BLEND:  state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = status.last_voice ? ST_IDLE : ST_WALK;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.capture    = in_valid && in_kind;
                cmd.load_chord = in_valid && !in_kind;
            end
            ST_WEIGHT: cmd.calc_weight = 1'b1;
            ST_SQUARE: cmd.calc_square = 1'b1;
            ST_CURVE:  cmd.calc_curve  = 1'b1;
            ST_WALK:   cmd.walk        = 1'b1;
            ST_DRIFT:  cmd.drift       = 1'b1;
            ST_SWARM:  cmd.swarm       = 1'b1;
            ST_BLEND:  cmd.blend       = 1'b1;
            ST_EMIT:
            begin
                cmd.emit       = status.out_free;
                cmd.voice_next = status.out_free && !status.last_voice;
            end
            default:   cmd = '0;
        endcase
    end

endmodule

@@ rtl/core/pscf_dp.sv @@
// ----------------------------------------------------------------------------
// Pitch swarm crossfader datapath
// Weight curve, root folding, random walks, chord store and output register.
// ----------------------------------------------------------------------------
module pscf_dp import pscf_pkg::*; #(
    parameter int VOICES = VOICES_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmd_t                      cmd,
    output stat_t                     status,
    input  logic [IDX_W-1:0]          chord_index,
    input  logic signed [PITCH_W-1:0] chord_value,
    input  logic signed [PITCH_W-1:0] root_pitch,
    input  logic signed [PITCH_W-1:0] envelope,
    input  logic [COUNT_W-1:0]        chord_count,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      out_ready,
    output logic                      out_valid,
    output logic [VOICE_W-1:0]        out_voice,
    output logic signed [PITCH_W-1:0] out_pitch,
    output logic                      out_last
);

    localparam int VW         = $clog2(VOICES);
    localparam int OFF_DIV    = 2 * (VOICES - 1);
    localparam int OFF_QSTEP  = 8192 / OFF_DIV;
    localparam int OFF_RSTEP  = 8192 % OFF_DIV;
    localparam int RW         = $clog2(2 * OFF_DIV);

    logic signed [PITCH_W-1:0] root_reg;
    logic signed [PITCH_W-1:0] env_reg;
    logic [COUNT_W-1:0]        count_reg;
    logic signed [PITCH_W-1:0] chord_reg [CHORDS];
    logic [STEP_W-1:0]         drift_step_reg;
    logic [SEED_W-1:0]         lfsr_reg;
    logic signed [WALK_W-1:0]  walk_pos_reg  [VOICES];
    logic signed [WALK_W-1:0]  walk_goal_reg [VOICES];

    logic signed [PITCH_W-1:0] root_adj_reg;
    logic [WEIGHT_W-1:0]       weight_reg;
    logic [COUNT_W-1:0]        n_reg;
    logic [32:0]               square_reg;
    logic [WEIGHT_W-1:0]       curve_reg;

    logic [VW-1:0]             vcnt_reg;
    logic [IDX_W-1:0]          mod_reg;
    logic [12:0]               offq_reg;
    logic [RW-1:0]             offr_reg;

    logic signed [WALK_W-1:0]  pos_new_reg;
    logic [10:0]               quo_reg;
    logic signed [17:0]        swarm_reg;
    logic signed [PITCH_W-1:0] target_reg;
    logic signed [36:0]        prod_reg;

    logic                      out_valid_reg;
    logic [VOICE_W-1:0]        out_voice_reg;
    logic signed [PITCH_W-1:0] out_pitch_reg;
    logic                      out_last_reg;

    // Root folding by whole volts.
    logic signed [18:0] root_ext;
    logic signed [18:0] dist_lo;
    logic signed [18:0] dist_hi;
    logic signed [18:0] sum_lo;
    logic signed [18:0] sum_hi;
    logic signed [18:0] root_adj_next;

    always_comb
    begin
        root_ext = {{2{root_reg[PITCH_W-1]}}, root_reg};
        dist_lo  = ROOT_LOW_LIMIT - root_ext;
        dist_hi  = root_ext - ROOT_HIGH_LIMIT;
        sum_lo   = dist_lo + ONE_V_MINUS_1;
        sum_hi   = dist_hi + ONE_V_MINUS_1;
        if (root_ext < ROOT_LOW_LIMIT)
        begin
            root_adj_next = root_ext + $signed({3'b000, sum_lo[15:12], 12'h000});
        end
        else if (root_ext > ROOT_HIGH_LIMIT)
        begin
            root_adj_next = root_ext - $signed({3'b000, sum_hi[15:12], 12'h000});
        end
        else
        begin
            root_adj_next = root_ext;
        end
    end

    // Envelope to blend weight; the division by nine uses a reciprocal.
    logic [19:0]         wnum;
    logic [39:0]         wprod;
    logic [WEIGHT_W-1:0] weight_next;

    always_comb
    begin
        wnum  = {env_reg[15:0], 4'b0000} + 20'd4;
        wprod = wnum * RECIP_9;
        if (env_reg >= ENV_TOP)
        begin
            weight_next = '0;
        end
        else if (env_reg <= ENV_BOTTOM)
        begin
            weight_next = WEIGHT_ONE;
        end
        else
        begin
            weight_next = WEIGHT_ONE - wprod[39:23];
        end
    end

    logic [COUNT_W-1:0] n_next;

    always_comb
    begin
        if (count_reg == '0)
        begin
            n_next = COUNT_W'(1);
        end
        else if (count_reg > COUNT_W'(CHORDS))
        begin
            n_next = COUNT_W'(CHORDS);
        end
        else
        begin
            n_next = count_reg;
        end
    end

    logic [33:0] square_next;
    logic [17:0] curve_factor;
    logic [50:0] curve_prod;

    always_comb
    begin
        square_next  = weight_reg * weight_reg;
        curve_factor = CURVE_3 - {weight_reg, 1'b0};
        curve_prod   = square_reg * curve_factor + 51'h0_8000_0000;
    end

    // Random walk of the current voice.
    logic signed [WALK_W:0]   pos_ext;
    logic signed [WALK_W:0]   goal_ext;
    logic signed [WALK_W:0]   step_ext;
    logic signed [WALK_W:0]   pos_next;
    logic                     redraw;
    logic [SEED_W-1:0]        lfsr_next;
    logic signed [WALK_W-1:0] goal_next;

    always_comb
    begin
        pos_ext  = {walk_pos_reg[vcnt_reg][WALK_W-1], walk_pos_reg[vcnt_reg]};
        goal_ext = {walk_goal_reg[vcnt_reg][WALK_W-1], walk_goal_reg[vcnt_reg]};
        step_ext = $signed({{(WALK_W+1-STEP_W){1'b0}}, drift_step_reg});
        if (pos_ext < goal_ext)
        begin
            pos_next = pos_ext + step_ext;
            redraw   = pos_next >= goal_ext;
        end
        else
        begin
            pos_next = pos_ext - step_ext;
            redraw   = pos_next <= goal_ext;
        end
        lfsr_next = {1'b0, lfsr_reg[SEED_W-1:1]} ^ (lfsr_reg[0] ? LFSR_TAPS : '0);
        goal_next = {~lfsr_next[24], ~lfsr_next[24], lfsr_next[23:0]};
    end

    // Drift term: the walk over 40960, rounded, as a shift and a divide by ten.
    logic signed [WALK_W:0] drift_x;
    logic signed [14:0]     drift_u;
    logic [29:0]            drift_prod;

    always_comb
    begin
        drift_x    = {pos_new_reg[WALK_W-1], pos_new_reg} + DRIFT_ROUND;
        drift_u    = drift_x[26:12] + DRIFT_BIAS;
        drift_prod = drift_u[13:0] * RECIP_10;
    end

    logic [IDX_W-1:0] target_idx;
    assign target_idx = n_reg[IDX_W-1:0] - IDX_W'(1) - mod_reg;

    logic signed [17:0] swarm_next;
    assign swarm_next = {root_adj_reg[PITCH_W-1], root_adj_reg}
                      + $signed({5'b00000, offq_reg})
                      + $signed({7'b0000000, quo_reg})
                      - SWARM_BIAS;

    logic signed [18:0] blend_diff;
    logic signed [36:0] prod_next;

    always_comb
    begin
        blend_diff = {{2{target_reg[PITCH_W-1]}}, target_reg}
                   - {swarm_reg[17], swarm_reg};
        prod_next  = blend_diff * $signed({1'b0, curve_reg});
    end

    logic signed [36:0]        round_sum;
    logic signed [21:0]        pitch_wide;
    logic signed [PITCH_W-1:0] pitch_next;

    always_comb
    begin
        round_sum  = prod_reg + BLEND_ROUND;
        pitch_wide = {{4{swarm_reg[17]}}, swarm_reg} + {round_sum[36], round_sum[36:16]};
        if (pitch_wide > PITCH_MAX)
        begin
            pitch_next = PITCH_MAX[PITCH_W-1:0];
        end
        else if (pitch_wide < -PITCH_MAX)
        begin
            pitch_next = PITCH_W'(-PITCH_MAX);
        end
        else
        begin
            pitch_next = pitch_wide[PITCH_W-1:0];
        end
    end

    logic [RW-1:0] offr_sum;
    logic          last_voice;

    assign offr_sum   = offr_reg + RW'(OFF_RSTEP);
    assign last_voice = vcnt_reg == VW'(VOICES - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drift_step_reg <= DRIFT_STEP_RESET;
            lfsr_reg       <= LFSR_RESET;
            for (int i = 0; i < CHORDS; i++)
            begin
                chord_reg[i] <= '0;
            end
            for (int i = 0; i < VOICES; i++)
            begin
                walk_pos_reg[i]  <= '0;
                walk_goal_reg[i] <= '0;
            end
            vcnt_reg      <= '0;
            mod_reg       <= '0;
            offq_reg      <= '0;
            offr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_DRIFT_STEP)
            begin
                drift_step_reg <= cfg_data[STEP_W-1:0];
            end
            if (cfg_we && cfg_index == CFG_RANDOM_SEED)
            begin
                lfsr_reg <= (cfg_data == '0) ? LFSR_RESET : cfg_data;
            end
            else if (cmd.walk && redraw)
            begin
                lfsr_reg <= lfsr_next;
            end
            if (cmd.load_chord)
            begin
                chord_reg[chord_index] <= chord_value;
            end
            if (cmd.walk)
            begin
                walk_pos_reg[vcnt_reg] <= pos_next[WALK_W-1:0];
                if (redraw)
                begin
                    walk_goal_reg[vcnt_reg] <= goal_next;
                end
            end
            if (cmd.calc_curve)
            begin
                vcnt_reg <= '0;
                mod_reg  <= '0;
                offq_reg <= '0;
                offr_reg <= RW'(VOICES - 1);
            end
            else if (cmd.voice_next)
            begin
                vcnt_reg <= vcnt_reg + VW'(1);
                mod_reg  <= (mod_reg == target_idx + mod_reg - target_idx
                             && mod_reg == n_reg[IDX_W-1:0] - IDX_W'(1))
                            ? '0 : mod_reg + IDX_W'(1);
                if (offr_sum >= RW'(OFF_DIV))
                begin
                    offr_reg <= offr_sum - RW'(OFF_DIV);
                    offq_reg <= offq_reg + 13'(OFF_QSTEP) + 13'd1;
                end
                else
                begin
                    offr_reg <= offr_sum;
                    offq_reg <= offq_reg + 13'(OFF_QSTEP);
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            root_reg  <= root_pitch;
            env_reg   <= envelope;
            count_reg <= chord_count;
        end
        if (cmd.calc_weight)
        begin
            root_adj_reg <= root_adj_next[PITCH_W-1:0];
            weight_reg   <= weight_next;
            n_reg        <= n_next;
        end
        if (cmd.calc_square)
        begin
            square_reg <= square_next[32:0];
        end
        if (cmd.calc_curve)
        begin
            curve_reg <= curve_prod[48:32];
        end
        if (cmd.walk)
        begin
            pos_new_reg <= pos_next[WALK_W-1:0];
        end
        if (cmd.drift)
        begin
            quo_reg    <= drift_prod[29:19];
            target_reg <= chord_reg[target_idx];
        end
        if (cmd.swarm)
        begin
            swarm_reg <= swarm_next;
        end
        if (cmd.blend)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.emit)
        begin
            out_voice_reg <= VOICE_W'(vcnt_reg);
            out_pitch_reg <= pitch_next;
            out_last_reg  <= last_voice;
        end
    end

    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.last_voice = last_voice;

    assign out_valid = out_valid_reg;
    assign out_voice = out_voice_reg;
    assign out_pitch = out_pitch_reg;
    assign out_last  = out_last_reg;

endmodule

@@ rtl/core/pitch_swarm_crossfader_top.sv @@
// ----------------------------------------------------------------------------
// Pitch swarm crossfader
// Blends a drifting swarm of voice pitches toward stored chord voltages.
// ----------------------------------------------------------------------------
//  Port      Modport  Moves
//  item      sink     chord load (kind 0) or sample tick (kind 1)
//  result    source   one blended pitch per voice, voice order, last on the end
//  cfg_*     write    drift_step (index 0), random_seed (index 1)
//
// A chord load is written into the chord store and leaves the controller idle.
// A tick runs the weight, square and curve setup steps, then the walk, drift,
// swarm, blend and emit steps of each voice in turn, on the one shared datapath.
// Reset restores the walks, the chord store and the register defaults at once.
// A voice waits in its last step while the output register is full and not taken.
// ----------------------------------------------------------------------------
module pitch_swarm_crossfader_top import pscf_pkg::*; #(
    parameter int VOICES = VOICES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    pscf_in_if.sink               item,
    pscf_out_if.source            result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t  cmd;
    stat_t status;

    pscf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_kind  (item.kind),
        .in_ready (item.ready),
        .status   (status),
        .cmd      (cmd)
    );

    pscf_dp #(
        .VOICES (VOICES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .chord_index (item.chord_index),
        .chord_value (item.chord_value),
        .root_pitch  (item.root_pitch),
        .envelope    (item.envelope),
        .chord_count (item.chord_count),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_ready   (result.ready),
        .out_valid   (result.valid),
        .out_voice   (result.voice),
        .out_pitch   (result.pitch),
        .out_last    (result.last)
    );

    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!result.valid || result.ready))
        else $error("Result register overwritten before its transfer.");

    a_tick_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready && item.kind) |=> !item.ready)
        else $error("Input taken while a tick is still in progress.");

    a_last_on_final_voice: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.last == (result.voice == VOICE_W'(VOICES - 1))))
        else $error("Last flag does not match the final voice.");

    a_pitch_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.pitch <= 17'sd40960 && result.pitch >= -17'sd40960))
        else $error("Result pitch outside the saturation range.");

endmodule

@@ sim/tb_pitch_swarm_crossfader_top.sv @@
// ----------------------------------------------------------------------------
// Pitch swarm crossfader testbench
// Sends chord loads and sample ticks over the item channel, writes drift_step
// and random_seed between phases, and checks every voice pitch against a
// behavioral predictor of the root fold, weight curve, random walks and blend.
// ----------------------------------------------------------------------------
module tb_pitch_swarm_crossfader_top import pscf_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int VOICES      = VOICES_DEF;
    localparam int TICK_CYCLES = 3 + 5 * VOICES;
    localparam int SETTLE      = TICK_CYCLES + 20;
    localparam int LONG_HOLD   = 500;
    localparam int MAX_GAP     = 16;
    localparam longint LIMIT_NS = 64'd6000000;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct {
        logic                      kind;
        logic [IDX_W-1:0]          chord_index;
        logic signed [PITCH_W-1:0] chord_value;
        logic signed [PITCH_W-1:0] root_pitch;
        logic signed [PITCH_W-1:0] envelope;
        logic [COUNT_W-1:0]        chord_count;
    } swarm_item_t;

    typedef struct {
        logic [VOICE_W-1:0]        voice;
        logic signed [PITCH_W-1:0] pitch;
        logic                      last;
    } voice_pitch_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pscf_in_if  item_ch ();
    pscf_out_if result_ch ();

    pitch_swarm_crossfader_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    swarm_item_t  pending_items[$];
    voice_pitch_t due_pitches[$];

    int          walk_pos[CHORDS];
    int          walk_goal[CHORDS];
    int          chord_mem[CHORDS];
    logic [31:0] lfsr_model;
    logic [15:0] step_model;

    swarm_item_t  offer;
    voice_pitch_t want;
    logic         offered;
    int           src_wait;
    int           sink_wait;
    int           long_left;
    int           hold_requests;
    int           holds_served;
    logic         steady;

    int fail_count;
    int ticks_sent;
    int loads_sent;
    int pitches_checked;
    int cfg_writes;

    always #2 clk = ~clk;

    function automatic int pick_gap();
        if (steady)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    function automatic longint floor_div(longint x, longint d);
        if (x >= 0)
            return x / d;
        return -((-x + d - 1) / d);
    endfunction

    function automatic int draw_walk_goal();
        logic lsb;
        lsb = lfsr_model[0];
        lfsr_model = lfsr_model >> 1;
        if (lsb)
            lfsr_model = lfsr_model ^ LFSR_TAPS;
        return int'({7'd0, lfsr_model[24:0]}) - 16777216;
    endfunction

    task automatic predict_tick(swarm_item_t it);
        longint root;
        longint env;
        longint w;
        longint e;
        longint n;
        longint d;
        longint offs;
        longint drift;
        longint swarm;
        longint target;
        longint pitch;
        int     step;
        voice_pitch_t r;
        root = it.root_pitch;
        if (root - 2458 < -16384)
        begin
            d = -16384 - (root - 2458);
            root = root + ((d + 4095) / 4096) * 4096;
        end
        else if (root + 2458 > 20480)
        begin
            d = root + 2458 - 20480;
            root = root - ((d + 4095) / 4096) * 4096;
        end
        env = it.envelope;
        if (env >= 36864)
            w = 0;
        else if (env * 10 <= 4096)
            w = 65536;
        else
            w = 65536 - (env * 16 + 4) / 9;
        e = (w * w * (196608 - 2 * w) + 64'sh80000000) >>> 32;
        n = it.chord_count;
        if (n < 1)
            n = 1;
        if (n > 16)
            n = 16;
        step = int'(step_model);
        for (int v = 0; v < VOICES; v++)
        begin
            if (walk_pos[v] < walk_goal[v])
            begin
                walk_pos[v] = walk_pos[v] + step;
                if (walk_pos[v] >= walk_goal[v])
                    walk_goal[v] = draw_walk_goal();
            end
            else
            begin
                walk_pos[v] = walk_pos[v] - step;
                if (walk_pos[v] <= walk_goal[v])
                    walk_goal[v] = draw_walk_goal();
            end
            offs = (8192 * longint'(v) + (VOICES - 1)) / (2 * (VOICES - 1)) - 2048;
            drift = floor_div(longint'(walk_pos[v]) + 20480, 40960);
            swarm = root + offs + drift;
            target = chord_mem[(n - 1) - (v % n)];
            pitch = swarm + floor_div((target - swarm) * e + 32768, 65536);
            if (pitch > 40960)
                pitch = 40960;
            if (pitch < -40960)
                pitch = -40960;
            r.voice = v[VOICE_W-1:0];
            r.pitch = pitch[PITCH_W-1:0];
            r.last = (v == VOICES - 1);
            due_pitches.push_back(r);
        end
    endtask

    task automatic apply_item(swarm_item_t it);
        if (it.kind == KIND_LOAD)
        begin
            chord_mem[it.chord_index] = it.chord_value;
            loads_sent++;
        end
        else
        begin
            predict_tick(it);
            ticks_sent++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offered = 1'b0;
            src_wait = 0;
            item_ch.valid <= 1'b0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                apply_item(offer);
                offered = 1'b0;
                src_wait = pick_gap();
            end
            if (!offered)
            begin
                if (src_wait > 0)
                    src_wait--;
                else if (pending_items.size() > 0)
                begin
                    offer = pending_items.pop_front();
                    offered = 1'b1;
                end
            end
            item_ch.valid       <= offered;
            item_ch.kind        <= offer.kind;
            item_ch.chord_index <= offer.chord_index;
            item_ch.chord_value <= offer.chord_value;
            item_ch.root_pitch  <= offer.root_pitch;
            item_ch.envelope    <= offer.envelope;
            item_ch.chord_count <= offer.chord_count;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sink_wait = 0;
            long_left = 0;
            holds_served = 0;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (due_pitches.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected transfer, voice %0d pitch %0d last %0b",
                             $time, result_ch.voice, result_ch.pitch, result_ch.last);
                end
                else
                begin
                    want = due_pitches.pop_front();
                    if (result_ch.voice !== want.voice)
                    begin
                        fail_count++;
                        $display("%0t: voice expected %0d actual %0d",
                                 $time, want.voice, result_ch.voice);
                    end
                    if (result_ch.pitch !== want.pitch)
                    begin
                        fail_count++;
                        $display("%0t: pitch of voice %0d expected %0d actual %0d",
                                 $time, want.voice, want.pitch, result_ch.pitch);
                    end
                    if (result_ch.last !== want.last)
                    begin
                        fail_count++;
                        $display("%0t: last of voice %0d expected %0b actual %0b",
                                 $time, want.voice, want.last, result_ch.last);
                    end
                    pitches_checked++;
                end
                sink_wait = pick_gap();
            end
            if (hold_requests != holds_served)
            begin
                holds_served++;
                long_left = LONG_HOLD;
            end
            if (long_left > 0)
            begin
                long_left--;
                result_ch.ready <= 1'b0;
            end
            else if (sink_wait > 0)
            begin
                sink_wait--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    function automatic logic signed [PITCH_W-1:0] random_volt();
        logic [31:0] raw;
        raw = $urandom();
        if ($urandom_range(0, 9) == 0)
            return raw[PITCH_W-1:0];
        raw = int'($urandom_range(0, 81920)) - 40960;
        return raw[PITCH_W-1:0];
    endfunction

    function automatic logic signed [PITCH_W-1:0] random_envelope();
        logic [31:0] raw;
        int          pick;
        pick = $urandom_range(0, 9);
        raw = $urandom();
        if (pick == 0)
            return raw[PITCH_W-1:0];
        if (pick <= 5)
            raw = $urandom_range(0, 37500);
        else
            raw = int'($urandom_range(0, 81920)) - 40960;
        return raw[PITCH_W-1:0];
    endfunction

    function automatic swarm_item_t random_item();
        swarm_item_t it;
        it.kind = ($urandom_range(0, 9) < 6) ? KIND_TICK : KIND_LOAD;
        it.chord_index = IDX_W'($urandom_range(0, CHORDS - 1));
        it.chord_value = random_volt();
        it.root_pitch = random_volt();
        it.envelope = random_envelope();
        if ($urandom_range(0, 9) == 0)
            it.chord_count = COUNT_W'($urandom_range(0, 31));
        else
            it.chord_count = COUNT_W'($urandom_range(0, 16));
        return it;
    endfunction

    task automatic push_load(int index, int value);
        swarm_item_t it;
        it = random_item();
        it.kind = KIND_LOAD;
        it.chord_index = index[IDX_W-1:0];
        it.chord_value = value[PITCH_W-1:0];
        pending_items.push_back(it);
    endtask

    task automatic push_tick(int root, int env, int count);
        swarm_item_t it;
        it = random_item();
        it.kind = KIND_TICK;
        it.root_pitch = root[PITCH_W-1:0];
        it.envelope = env[PITCH_W-1:0];
        it.chord_count = count[COUNT_W-1:0];
        pending_items.push_back(it);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || item_ch.valid || due_pitches.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (index)
            CFG_DRIFT_STEP:  step_model = data[STEP_W-1:0];
            CFG_RANDOM_SEED: lfsr_model = (data != 0) ? data : 32'd1;
            default:         ;
        endcase
        cfg_writes++;
        @(negedge clk);
    endtask

    task automatic reconfigure(logic [CFG_DATA_W-1:0] step, logic [CFG_DATA_W-1:0] seed);
        wait_drained();
        repeat (SETTLE) @(negedge clk);
        write_reg(CFG_DRIFT_STEP, step);
        write_reg(CFG_RANDOM_SEED, seed);
    endtask

    task automatic run_random(int count);
        for (int i = 0; i < count; i++)
        begin
            pending_items.push_back(random_item());
            if ($urandom_range(0, 59) == 0)
                wait_drained();
            while (pending_items.size() > 2)
                @(negedge clk);
        end
    endtask

    initial
    begin
        #(LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        item_ch.valid = 1'b0;
        item_ch.kind = KIND_LOAD;
        item_ch.chord_index = '0;
        item_ch.chord_value = '0;
        item_ch.root_pitch = '0;
        item_ch.envelope = '0;
        item_ch.chord_count = '0;
        result_ch.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_DRIFT_STEP;
        cfg_data = '0;
        steady = 1'b0;
        hold_requests = 0;
        fail_count = 0;
        ticks_sent = 0;
        loads_sent = 0;
        pitches_checked = 0;
        cfg_writes = 0;
        step_model = DRIFT_STEP_RESET;
        lfsr_model = LFSR_RESET;
        for (int i = 0; i < CHORDS; i++)
        begin
            walk_pos[i] = 0;
            walk_goal[i] = 0;
            chord_mem[i] = 0;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The first tick redraws every goal; the rest walk the fold, weight and count edges.
        push_tick(0, 0, 0);
        push_load(0, -40960);
        push_load(15, 40960);
        push_load(3, -65536);
        push_load(12, 65535);
        push_load(7, 1234);
        push_load(10, -777);
        push_tick(-65536, 36864, 16);
        push_tick(65535, 36863, 17);
        push_tick(-40960, 409, 1);
        push_tick(40960, 410, 31);
        push_tick(-13926, 65535, 7);
        push_tick(-13927, -65536, 16);
        push_tick(18022, 20000, 5);
        push_tick(18023, 4096, 16);
        push_tick(0, 36865, 2);
        push_load(15, 0);
        push_load(9, -4097);
        push_tick(4095, 18432, 16);
        push_tick(-20000, 1000, 12);

        reconfigure(32'd0, 32'd0);
        write_reg(CFG_SPARE_A, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE_B, 32'h0000_1234);
        run_random(60);

        reconfigure(32'd65535, 32'hFFFF_FFFF);
        hold_requests++;
        run_random(90);

        reconfigure($urandom_range(1, 65535), $urandom());
        steady = 1'b1;
        run_random(60);
        steady = 1'b0;

        reconfigure(32'd1, $urandom());
        run_random(40);
        wait_drained();
        run_random(40);

        reconfigure({16'hFFFF, DRIFT_STEP_RESET}, LFSR_RESET);
        run_random(110);

        wait_drained();
        repeat (SETTLE) @(negedge clk);
        $display("summary: %0d ticks and %0d chord loads transferred, %0d register writes",
                 ticks_sent, loads_sent, cfg_writes);
        $display("summary: %0d voice pitches checked, %0d mismatches",
                 pitches_checked, fail_count);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ pitch_swarm_crossfader_top.f @@
rtl/core/pscf_pkg.sv
rtl/core/pscf_in_if.sv
rtl/core/pscf_out_if.sv
rtl/core/pscf_ctrl.sv
rtl/core/pscf_dp.sv
rtl/core/pitch_swarm_crossfader_top.sv
sim/tb_pitch_swarm_crossfader_top.sv
